>>> rtl/core/timestamp_pair_matcher_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the timestamp pair matcher
// Shorthand for clocked implication checks, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef TIMESTAMP_PAIR_MATCHER_UNIT_ASSERT_SVH
`define TIMESTAMP_PAIR_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define TPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tpm_pkg.sv
// ---------------------------------------------------------------------------
// tpm_pkg
// Types and codes shared by the timestamp pair matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package tpm_pkg;

    // request codes
    localparam logic [1:0] REQ_PUSH_PRI = 2'd0;
    localparam logic [1:0] REQ_PUSH_SEC = 2'd1;
    localparam logic [1:0] REQ_PAIR     = 2'd2;

    // result status codes
    localparam logic [2:0] ST_PUSHED    = 3'd0;
    localparam logic [2:0] ST_EVICTED   = 3'd1;
    localparam logic [2:0] ST_PAIRED    = 3'd2;
    localparam logic [2:0] ST_PRI_DROP  = 3'd3;
    localparam logic [2:0] ST_SEC_DROP  = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_LIMIT     = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [47:0] stamp;
        logic [15:0] frame_tag;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] primary_tag;
        logic [15:0] secondary_tag;
        logic [15:0] evicted_tag;
        logic [47:0] pair_gap;
        logic [31:0] primary_drop_total;
        logic [31:0] secondary_drop_total;
    } t_out_item;

    typedef struct packed {
        logic [47:0] stamp;
        logic [15:0] tag;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_CALC,
        S_PUSH_RD,
        S_PUSH_UPD,
        S_PAIR_START,
        S_PAIR_SCAN,
        S_PAIR_DRAIN,
        S_PAIR_DECIDE
    } t_state_main;

    typedef enum logic {
        R_FREE,
        R_HOLD
    } t_state_resp;

endpackage

`default_nettype wire

>>> rtl/core/timestamp_pair_matcher_unit.sv
// Steps: a push works out its eviction count, reads the last evicted slot, then updates the
// buffer and stages its result; a pair request that scans starts, reads one secondary a cycle,
// drains the read/difference/compare pipe and decides; an empty or unused request is staged at the start.
// One transaction at a time; the next is taken once the result is staged, later while a
// stalled output still holds the previous result. Reset clears pointers, counts and drop
// counters and restores the default configuration; buffer memories are never cleared.
// ---------------------------------------------------------------------------
// timestamp_pair_matcher_unit
// Two bounded timestamp FIFOs with push/evict and nearest-stamp pairing.
// ---------------------------------------------------------------------------
`default_nettype none
`include "timestamp_pair_matcher_unit_assert.svh"

module timestamp_pair_matcher_unit
    import tpm_pkg::*;
#(
    parameter int FIFO_DEPTH = 128
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int LW = (CW > 8) ? CW : 8;

    // index wrap: head plus offset, both below twice the depth
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] h,
                                             input logic [CW-1:0] x);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(x);
        if (s >= (CW+1)'(FIFO_DEPTH)) begin
            s = s - (CW+1)'(FIFO_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    t_state_main r_state, n_state;
    t_state_resp out_st;

    t_in_item    r_req;
    logic [19:0] r_thresh;
    logic [7:0]  r_limit;

    logic [AW-1:0] r_p_head, n_p_head, r_s_head, n_s_head;
    logic [CW-1:0] r_p_cnt, n_p_cnt, r_s_cnt, n_s_cnt;
    logic [31:0]   r_p_drops, n_p_drops, r_s_drops, n_s_drops;
    logic [CW:0]   r_evn, n_evn;

    t_out_item r_res, n_res;
    logic      res_load;
    t_out_item r_out;
    logic      r_out_vld;

    // buffer memories
    t_entry m_prim [FIFO_DEPTH];
    t_entry m_sec  [FIFO_DEPTH];
    t_entry r_p_rdata, r_s_rdata;
    logic [AW-1:0] p_raddr, s_raddr, waddr;
    logic          p_we, s_we;

    // scan pipeline
    logic [AW-1:0] r_iss_idx, r_idx1, r_idx2, r_best_idx;
    logic          r_v1, r_v2;
    logic [47:0]   r_dt, r_st2, r_best_dt, r_best_stamp;
    logic [15:0]   r_tg2, r_best_tag, r_sfront_tag;
    logic          scan_issue, scan_last;

    logic          sel_sec;
    logic [AW-1:0] cur_head;
    logic [CW-1:0] cur_cnt;
    logic [LW-1:0] lim;
    logic [LW:0]   total;
    logic [47:0]   d_fwd, d_bwd, d_abs;
    logic          pair_fail, pri_older;

    assign sel_sec  = (r_req.req_type == REQ_PUSH_SEC);
    assign cur_head = sel_sec ? r_s_head : r_p_head;
    assign cur_cnt  = sel_sec ? r_s_cnt : r_p_cnt;

    assign lim   = (LW'(r_limit) > LW'(FIFO_DEPTH)) ? LW'(FIFO_DEPTH) : LW'(r_limit);
    assign total = (LW+1)'(cur_cnt) + (LW+1)'(1);

    assign scan_issue = (r_state == S_PAIR_SCAN);
    assign scan_last  = (CW'(r_iss_idx) == r_s_cnt - CW'(1));

    assign d_fwd = r_s_rdata.stamp - r_p_rdata.stamp;
    assign d_bwd = r_p_rdata.stamp - r_s_rdata.stamp;
    assign d_abs = (r_s_rdata.stamp > r_p_rdata.stamp) ? d_fwd : d_bwd;

    assign pair_fail = (r_best_dt > 48'(r_thresh));
    assign pri_older = (r_p_rdata.stamp < r_best_stamp);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.req_type == REQ_PUSH_PRI ||
                        i_in_data.req_type == REQ_PUSH_SEC) begin
                        n_state = S_PUSH_CALC;
                    end else begin
                        n_state = S_PAIR_START;
                    end
                end
            end
            S_PUSH_CALC: n_state = S_PUSH_RD;
            S_PUSH_RD:   n_state = S_PUSH_UPD;
            S_PUSH_UPD:  n_state = S_IDLE;
            S_PAIR_START: begin
                if (r_req.req_type != REQ_PAIR || r_p_cnt == '0 || r_s_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PAIR_SCAN;
                end
            end
            S_PAIR_SCAN: begin
                if (scan_last) begin
                    n_state = S_PAIR_DRAIN;
                end
            end
            S_PAIR_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_PAIR_DECIDE;
                end
            end
            S_PAIR_DECIDE: n_state = S_IDLE;
            default:       n_state = S_IDLE;
        endcase
        // hold in place until the staged result has moved out
        if (res_load && out_st == R_HOLD) begin
            n_state = r_state;
        end
    end

    // datapath and memory control
    always_comb begin
        n_p_head  = r_p_head;
        n_s_head  = r_s_head;
        n_p_cnt   = r_p_cnt;
        n_s_cnt   = r_s_cnt;
        n_p_drops = r_p_drops;
        n_s_drops = r_s_drops;
        n_evn     = r_evn;
        n_res     = r_res;
        res_load  = 1'b0;
        p_raddr   = r_p_head;
        s_raddr   = r_s_head;
        waddr     = f_slot(cur_head, cur_cnt);
        p_we      = 1'b0;
        s_we      = 1'b0;

        n_res.primary_tag   = '0;
        n_res.secondary_tag = '0;
        n_res.evicted_tag   = '0;
        n_res.pair_gap      = '0;

        unique case (r_state)
            S_PUSH_CALC: begin
                n_evn = (total > (LW+1)'(lim)) ? (CW+1)'(total - (LW+1)'(lim)) : '0;
            end
            S_PUSH_RD: begin
                if (sel_sec) begin
                    s_raddr = f_slot(r_s_head, CW'(r_evn - (CW+1)'(1)));
                end else begin
                    p_raddr = f_slot(r_p_head, CW'(r_evn - (CW+1)'(1)));
                end
            end
            S_PUSH_UPD: begin
                // keep reading the last evicted slot while the result waits
                if (sel_sec) begin
                    s_raddr = f_slot(r_s_head, CW'(r_evn - (CW+1)'(1)));
                end else begin
                    p_raddr = f_slot(r_p_head, CW'(r_evn - (CW+1)'(1)));
                end
                res_load     = 1'b1;
                n_res.status = (r_evn != '0) ? ST_EVICTED : ST_PUSHED;
                if (r_evn > (CW+1)'(cur_cnt)) begin
                    // limit of zero: the pushed entry goes too
                    n_res.evicted_tag = r_req.frame_tag;
                    if (sel_sec) begin
                        n_s_head = '0;
                        n_s_cnt  = '0;
                    end else begin
                        n_p_head = '0;
                        n_p_cnt  = '0;
                    end
                end else begin
                    if (r_evn != '0) begin
                        n_res.evicted_tag = sel_sec ? r_s_rdata.tag : r_p_rdata.tag;
                    end
                    if (sel_sec) begin
                        s_we     = 1'b1;
                        n_s_head = f_slot(r_s_head, CW'(r_evn));
                        n_s_cnt  = CW'((CW+1)'(r_s_cnt) - r_evn + (CW+1)'(1));
                    end else begin
                        p_we     = 1'b1;
                        n_p_head = f_slot(r_p_head, CW'(r_evn));
                        n_p_cnt  = CW'((CW+1)'(r_p_cnt) - r_evn + (CW+1)'(1));
                    end
                end
                if (sel_sec) begin
                    n_s_drops = r_s_drops + 32'(r_evn);
                end else begin
                    n_p_drops = r_p_drops + 32'(r_evn);
                end
            end
            S_PAIR_START: begin
                n_res.status = ST_EMPTY;
                res_load     = (r_req.req_type != REQ_PAIR || r_p_cnt == '0 ||
                                r_s_cnt == '0);
            end
            S_PAIR_SCAN: begin
                s_raddr = f_slot(r_s_head, CW'(r_iss_idx));
            end
            S_PAIR_DECIDE: begin
                res_load = 1'b1;
                if (pair_fail && pri_older) begin
                    n_res.status      = ST_PRI_DROP;
                    n_res.primary_tag = r_p_rdata.tag;
                    n_p_head          = f_slot(r_p_head, CW'(1));
                    n_p_cnt           = r_p_cnt - CW'(1);
                    n_p_drops         = r_p_drops + 32'd1;
                end else if (pair_fail) begin
                    n_res.status        = ST_SEC_DROP;
                    n_res.secondary_tag = r_sfront_tag;
                    n_s_head            = f_slot(r_s_head, CW'(1));
                    n_s_cnt             = r_s_cnt - CW'(1);
                    n_s_drops           = r_s_drops + 32'd1;
                end else begin
                    n_res.status        = ST_PAIRED;
                    n_res.primary_tag   = r_p_rdata.tag;
                    n_res.secondary_tag = r_best_tag;
                    n_res.pair_gap      = r_best_dt;
                    n_p_head            = f_slot(r_p_head, CW'(1));
                    n_p_cnt             = r_p_cnt - CW'(1);
                    n_s_head            = f_slot(r_s_head, CW'(r_best_idx) + CW'(1));
                    n_s_cnt             = r_s_cnt - CW'(r_best_idx) - CW'(1);
                end
            end
            default: begin
            end
        endcase

        n_res.primary_drop_total   = n_p_drops;
        n_res.secondary_drop_total = n_s_drops;

        // no state update while the result cannot be staged
        if (res_load && out_st == R_HOLD) begin
            n_p_head  = r_p_head;
            n_s_head  = r_s_head;
            n_p_cnt   = r_p_cnt;
            n_s_cnt   = r_s_cnt;
            n_p_drops = r_p_drops;
            n_s_drops = r_s_drops;
            p_we      = 1'b0;
            s_we      = 1'b0;
        end
    end

    // staging slot is busy when the output holds a transaction that is stalled
    always_comb begin
        out_st = (r_out_vld && i_out_stall) ? R_HOLD : R_FREE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_p_head  <= '0;
            r_s_head  <= '0;
            r_p_cnt   <= '0;
            r_s_cnt   <= '0;
            r_p_drops <= '0;
            r_s_drops <= '0;
            r_thresh  <= 20'd20000;
            r_limit   <= 8'd90;
            r_out_vld <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_head  <= n_p_head;
            r_s_head  <= n_s_head;
            r_p_cnt   <= n_p_cnt;
            r_s_cnt   <= n_s_cnt;
            r_p_drops <= n_p_drops;
            r_s_drops <= n_s_drops;
            r_v1      <= scan_issue;
            r_v2      <= r_v1;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_THRESHOLD: r_thresh <= i_cfg_data;
                    CFG_LIMIT:     r_limit  <= i_cfg_data[7:0];
                    default:       r_limit  <= r_limit;
                endcase
            end
            if (res_load && out_st == R_FREE) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_evn <= n_evn;
        r_res <= n_res;
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in_data;
        end
        if (res_load && out_st == R_FREE) begin
            r_out <= n_res;
        end
        // scan: issue, difference, keep the best
        if (r_state == S_PAIR_START) begin
            r_iss_idx <= '0;
        end else if (scan_issue) begin
            r_iss_idx <= r_iss_idx + AW'(1);
        end
        r_idx1 <= r_iss_idx;
        if (r_v1) begin
            r_dt   <= d_abs;
            r_st2  <= r_s_rdata.stamp;
            r_tg2  <= r_s_rdata.tag;
            r_idx2 <= r_idx1;
        end
        if (r_v2) begin
            if (r_idx2 == '0 || r_dt < r_best_dt) begin
                r_best_dt    <= r_dt;
                r_best_idx   <= r_idx2;
                r_best_stamp <= r_st2;
                r_best_tag   <= r_tg2;
            end
            if (r_idx2 == '0) begin
                r_sfront_tag <= r_tg2;
            end
        end
    end

    // buffer memories
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            m_prim[waddr] <= '{stamp: r_req.stamp, tag: r_req.frame_tag};
        end
        r_p_rdata <= m_prim[p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            m_sec[waddr] <= '{stamp: r_req.stamp, tag: r_req.frame_tag};
        end
        r_s_rdata <= m_sec[s_raddr];
    end

    `TPM_ASSERT_IMP(a_pri_cnt_bound, 1'b1, r_p_cnt <= CW'(FIFO_DEPTH), "primary count overflow")
    `TPM_ASSERT_IMP(a_sec_cnt_bound, 1'b1, r_s_cnt <= CW'(FIFO_DEPTH), "secondary count overflow")
    `TPM_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, r_state != S_IDLE, "idle")
    `TPM_ASSERT_IMP(a_best_idx, r_state == S_PAIR_DECIDE, CW'(r_best_idx) < r_s_cnt, "best idx")
    `TPM_ASSERT_NXT(a_result_staged, res_load && out_st == R_FREE, r_out_vld, "not staged")

endmodule

`default_nettype wire

>>> sim/tb.sv
// ---------------------------------------------------------------------------
// tb: timestamp pair matcher testbench
// Drives push and pair requests through the stall handshake, writes both
// configuration registers between phases, and checks every result field
// against an in-bench model of the two bounded timestamp FIFOs.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpm_pkg::*;

    localparam int DEPTH        = 128;
    localparam int PRI          = 0;
    localparam int SEC          = 1;
    localparam int NUM_PHASES   = 13;
    localparam int PHASE_ITEMS  = 146;
    localparam int IDLE_SETTLE  = 8;
    localparam int FLUSH_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 2000000;

    // request code the block leaves unused
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in_data   = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic [19:0] i_cfg_data = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       o_cfg_ready;

    timestamp_pair_matcher_unit #(.FIFO_DEPTH(DEPTH)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // model state: both FIFOs and the configuration
    t_entry      fifo_buf [2][DEPTH];
    int unsigned fifo_head [2];
    int unsigned fifo_count [2];
    logic [31:0] fifo_drops [2];
    logic [19:0] thr_reg;
    logic [7:0]  limit_reg;

    t_out_item   pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // random stream shaping, per phase
    logic [47:0] base_stamp;
    int unsigned spread;

    typedef struct {
        bit          is_cfg;
        logic        cfg_idx;
        logic [19:0] cfg_val;
        t_in_item    item;
        bit          typed;
        t_out_item   want;
    } t_dir_row;

    t_dir_row    dir_rows [$];

    function automatic void add_row(input t_dir_row row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void drop_front(input int side, input int unsigned n);
        fifo_head[side]  = (fifo_head[side] + n) % DEPTH;
        fifo_count[side] = fifo_count[side] - n;
    endfunction

    function automatic t_out_item matcher_next_result(input t_in_item x);
        t_out_item   r;
        int          side;
        int unsigned lim, n, best, i;
        logic [47:0] pts, s, dt, best_dt;
        r = '0;
        r.status = ST_EMPTY;
        if (x.req_type == REQ_PUSH_PRI || x.req_type == REQ_PUSH_SEC) begin
            side = (x.req_type == REQ_PUSH_PRI) ? PRI : SEC;
            lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
            n = (fifo_count[side] + 1 > lim) ? fifo_count[side] + 1 - lim : 0;
            if (n > fifo_count[side]) begin
                // zero limit: the new entry goes out with the rest
                fifo_head[side]  = 0;
                fifo_count[side] = 0;
                r.evicted_tag = x.frame_tag;
            end else begin
                if (n > 0) begin
                    r.evicted_tag = fifo_buf[side][(fifo_head[side] + n - 1) % DEPTH].tag;
                    drop_front(side, n);
                end
                fifo_buf[side][(fifo_head[side] + fifo_count[side]) % DEPTH] =
                    '{stamp: x.stamp, tag: x.frame_tag};
                fifo_count[side]++;
            end
            fifo_drops[side] = fifo_drops[side] + n;
            r.status = (n > 0) ? ST_EVICTED : ST_PUSHED;
        end else if (x.req_type == REQ_PAIR && fifo_count[PRI] > 0 && fifo_count[SEC] > 0) begin
            pts = fifo_buf[PRI][fifo_head[PRI]].stamp;
            best = 0;
            best_dt = '0;
            for (i = 0; i < fifo_count[SEC]; i++) begin
                s = fifo_buf[SEC][(fifo_head[SEC] + i) % DEPTH].stamp;
                dt = (s > pts) ? s - pts : pts - s;
                if (i == 0 || dt < best_dt) begin
                    best_dt = dt;
                    best = i;
                end
            end
            if (best_dt > {28'd0, thr_reg}) begin
                if (pts < fifo_buf[SEC][(fifo_head[SEC] + best) % DEPTH].stamp) begin
                    r.primary_tag = fifo_buf[PRI][fifo_head[PRI]].tag;
                    drop_front(PRI, 1);
                    fifo_drops[PRI] = fifo_drops[PRI] + 1;
                    r.status = ST_PRI_DROP;
                end else begin
                    r.secondary_tag = fifo_buf[SEC][fifo_head[SEC]].tag;
                    drop_front(SEC, 1);
                    fifo_drops[SEC] = fifo_drops[SEC] + 1;
                    r.status = ST_SEC_DROP;
                end
            end else begin
                // entries skipped before the match leave without counting
                r.primary_tag   = fifo_buf[PRI][fifo_head[PRI]].tag;
                r.secondary_tag = fifo_buf[SEC][(fifo_head[SEC] + best) % DEPTH].tag;
                drop_front(PRI, 1);
                drop_front(SEC, best + 1);
                r.pair_gap = best_dt;
                r.status = ST_PAIRED;
            end
        end
        r.primary_drop_total   = fifo_drops[PRI];
        r.secondary_drop_total = fifo_drops[SEC];
        return r;
    endfunction

    function automatic t_out_item mk_out(input logic [2:0] st, input logic [15:0] ptag,
                                         input logic [15:0] stag, input logic [15:0] etag,
                                         input logic [47:0] gap, input logic [31:0] pd,
                                         input logic [31:0] sd);
        t_out_item r;
        r = '{status: st, primary_tag: ptag, secondary_tag: stag, evicted_tag: etag,
              pair_gap: gap, primary_drop_total: pd, secondary_drop_total: sd};
        return r;
    endfunction

    function automatic t_dir_row req_row(input logic [1:0] req, input logic [47:0] stamp,
                                         input logic [15:0] tag);
        t_dir_row row;
        row = '{is_cfg: 1'b0, cfg_idx: 1'b0, cfg_val: '0,
                item: '{req_type: req, stamp: stamp, frame_tag: tag},
                typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_dir_row typed_row(input logic [1:0] req, input logic [47:0] stamp,
                                           input logic [15:0] tag, input t_out_item want);
        t_dir_row row;
        row = req_row(req, stamp, tag);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input logic idx, input logic [19:0] val);
        t_dir_row row;
        row = req_row(REQ_PUSH_PRI, '0, '0);
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        return row;
    endfunction

    function automatic t_in_item next_random_item();
        t_in_item    x;
        int unsigned r;
        logic [63:0] raw;
        r = $urandom_range(0, 99);
        raw = {$urandom, $urandom};
        x.frame_tag = 16'($urandom);
        if (r < 3)
            x.req_type = REQ_UNUSED;
        else if (r < 40)
            x.req_type = REQ_PUSH_PRI;
        else if (r < 77)
            x.req_type = REQ_PUSH_SEC;
        else
            x.req_type = REQ_PAIR;
        if ($urandom_range(0, 99) < 8) begin
            x.stamp = raw[47:0];
        end else begin
            // both streams track one advancing clock with jitter
            x.stamp = base_stamp + 48'($urandom_range(0, spread));
            if (x.req_type != REQ_PAIR)
                base_stamp = base_stamp + 48'($urandom_range(0, spread / 2 + 1));
        end
        return x;
    endfunction

    task automatic send_item(input t_in_item x, input bit typed, input t_out_item want);
        t_out_item p;
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        do @(posedge i_clk); while (o_in_stall);
        p = matcher_next_result(x);
        pending_results.insert(pending_results.size(), typed ? want : p);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [19:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_THRESHOLD)
            thr_reg = val;
        else
            limit_reg = val[7:0];
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result expected none got %h", $time, o_out_data);
                mismatch_count++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("status", 48'(want.status), 48'(o_out_data.status));
                check_field("primary_tag", 48'(want.primary_tag),
                            48'(o_out_data.primary_tag));
                check_field("secondary_tag", 48'(want.secondary_tag),
                            48'(o_out_data.secondary_tag));
                check_field("evicted_tag", 48'(want.evicted_tag),
                            48'(o_out_data.evicted_tag));
                check_field("pair_gap", want.pair_gap, o_out_data.pair_gap);
                check_field("primary_drop_total", 48'(want.primary_drop_total),
                            48'(o_out_data.primary_drop_total));
                check_field("secondary_drop_total", 48'(want.secondary_drop_total),
                            48'(o_out_data.secondary_drop_total));
            end
        end
    end

    // receiver backpressure: segments of free, random, long and alternating stalls
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;
    int unsigned stall_pos  = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 64);
            stall_pos  <= 0;
        end else begin
            stall_left <= stall_left - 1;
            stall_pos  <= stall_pos + 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            2: i_out_stall <= ((stall_pos % 9) < 6);
            default: i_out_stall <= stall_pos[0];
        endcase
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        int unsigned ph, sent, burst;
        logic [19:0] thr_val;
        logic [7:0]  lim_val;
        t_in_item    item;

        fifo_head  = '{0, 0};
        fifo_count = '{0, 0};
        fifo_drops = '{32'd0, 32'd0};
        thr_reg    = 20'd20000;
        limit_reg  = 8'd90;

        // empty and unused requests, stamp extremes, drop and equal-stamp pairing
        add_row(typed_row(REQ_PAIR, '0, '0, mk_out(ST_EMPTY, 0, 0, 0, 0, 0, 0)));
        add_row(typed_row(REQ_UNUSED, '1, '1, mk_out(ST_EMPTY, 0, 0, 0, 0, 0, 0)));
        add_row(typed_row(REQ_PUSH_PRI, '0, '0, mk_out(ST_PUSHED, 0, 0, 0, 0, 0, 0)));
        add_row(typed_row(REQ_PAIR, '0, '0, mk_out(ST_EMPTY, 0, 0, 0, 0, 0, 0)));
        add_row(typed_row(REQ_PUSH_SEC, '1, '1, mk_out(ST_PUSHED, 0, 0, 0, 0, 0, 0)));
        add_row(typed_row(REQ_PAIR, '0, '0, mk_out(ST_PRI_DROP, 0, 0, 0, 0, 1, 0)));
        add_row(typed_row(REQ_PUSH_PRI, '1, 16'hAAAA,
                          mk_out(ST_PUSHED, 0, 0, 0, 0, 1, 0)));
        add_row(typed_row(REQ_PAIR, '0, '0,
                          mk_out(ST_PAIRED, 16'hAAAA, 16'hFFFF, 0, 0, 1, 0)));
        // primary newer than secondary: secondary front dropped
        add_row(req_row(REQ_PUSH_PRI, 48'd100000, 16'd1));
        add_row(req_row(REQ_PUSH_SEC, 48'd10, 16'd2));
        add_row(req_row(REQ_PAIR, '0, '0));
        add_row(req_row(REQ_PAIR, '0, '0));
        // tie goes to the first entry, then a match that skips an entry
        add_row(req_row(REQ_PUSH_SEC, 48'd99900, 16'd3));
        add_row(req_row(REQ_PUSH_SEC, 48'd100100, 16'd4));
        add_row(req_row(REQ_PUSH_SEC, 48'd100300, 16'd5));
        add_row(req_row(REQ_PAIR, '0, '0));
        add_row(req_row(REQ_PUSH_PRI, 48'd100290, 16'd6));
        add_row(req_row(REQ_PAIR, '0, '0));
        // zero limit evicts the pushed entry itself
        add_row(cfg_row(CFG_LIMIT, 20'd0));
        add_row(req_row(REQ_PUSH_SEC, 48'h123456789ABC, 16'h1234));
        // lowered limit evicts several at once
        add_row(cfg_row(CFG_LIMIT, 20'd2));
        add_row(req_row(REQ_PUSH_PRI, 48'd5000, 16'd10));
        add_row(req_row(REQ_PUSH_PRI, 48'd6000, 16'd11));
        add_row(req_row(REQ_PUSH_PRI, 48'd7000, 16'd12));
        add_row(cfg_row(CFG_LIMIT, 20'd1));
        add_row(req_row(REQ_PUSH_PRI, 48'd8000, 16'd13));
        // limit above depth, threshold extremes
        add_row(cfg_row(CFG_LIMIT, 20'd255));
        add_row(cfg_row(CFG_THRESHOLD, 20'd0));
        add_row(req_row(REQ_PUSH_SEC, 48'd8001, 16'd14));
        add_row(req_row(REQ_PAIR, '0, '0));
        add_row(cfg_row(CFG_THRESHOLD, 20'd1000000));
        add_row(req_row(REQ_PUSH_PRI, 48'd2000000, 16'd15));
        add_row(req_row(REQ_PAIR, '0, '0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                wait_idle();
                write_reg(dir_rows[k].cfg_idx, dir_rows[k].cfg_val);
            end else begin
                send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin thr_val = 20'd1000000; lim_val = 8'd128; end
                1: begin thr_val = 20'd0; lim_val = 8'd1; end
                2: begin thr_val = 20'($urandom_range(0, 60000)); lim_val = 8'd255; end
                3: begin thr_val = 20'd20000; lim_val = 8'd0; end
                default: begin
                    thr_val = ($urandom_range(0, 1) == 0) ? 20'($urandom_range(0, 1000000))
                                                          : 20'($urandom_range(0, 60000));
                    case ($urandom_range(0, 5))
                        0: lim_val = 8'($urandom_range(1, 4));
                        1: lim_val = 8'($urandom_range(5, 32));
                        2: lim_val = 8'($urandom_range(33, 128));
                        3: lim_val = 8'd90;
                        4: lim_val = 8'($urandom_range(129, 255));
                        default: lim_val = 8'd128;
                    endcase
                end
            endcase
            write_reg(CFG_THRESHOLD, thr_val);
            write_reg(CFG_LIMIT, {12'd0, lim_val});
            base_stamp = 48'({$urandom, $urandom});
            spread = $urandom_range(1, 40000);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 24);
                repeat (burst) begin
                    item = next_random_item();
                    send_item(item, 1'b0, '0);
                    if (item.req_type != REQ_UNUSED)
                        sent++;
                end
                case ($urandom_range(0, 19))
                    0: wait_idle();
                    1, 2, 3, 4, 5: ;   // keep streaming
                    default: begin
                        i_in_valid <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge i_clk);
                    end
                endcase
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/tpm_pkg.sv
rtl/core/timestamp_pair_matcher_unit.sv
sim/tb.sv
